// File: hw/rtl/vva_pkg.sv
// ----------------------------------------------------------------------------
// vva_pkg
// Shared types, constants and helpers for the three-component vector ALU.
// ----------------------------------------------------------------------------
package vva_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DW          = 32;
  localparam int NUM_LANES   = 3;
  localparam int WIDE_W      = 2 * DW + 2;
  localparam int SQ_W        = 2 * DW;
  localparam int ROOT_W      = DW;
  localparam int ROOT_STAGES = SQ_W / 2;
  localparam int DIVD_W      = DW + FRAC_BITS;
  localparam int DIV_STAGES  = DIVD_W;
  localparam int N_W         = FRAC_BITS + 2;
  localparam int PQ_W        = DW + N_W;
  localparam int PD_W        = PQ_W + 2 - FRAC_BITS;
  localparam int PR_W        = N_W + PD_W;
  localparam int LATENCY     = ROOT_STAGES + DIV_STAGES + 8;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_SCALE     = 4'd2,
    OP_DIVIDE    = 4'd3,
    OP_COMPARE   = 4'd4,
    OP_LENGTH    = 4'd5,
    OP_SQLENGTH  = 4'd6,
    OP_NORMALIZE = 4'd7,
    OP_DOT       = 4'd8,
    OP_CROSS     = 4'd9,
    OP_PROJECT   = 4'd10
  } op_t;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_ZERO = 2'd1;
  localparam logic [1:0] FAULT_SAT  = 2'd2;

  localparam logic signed [WIDE_W-1:0] SMAX_W = {{(WIDE_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] SMIN_W = {{(WIDE_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [3:0]              operation;
    logic signed [DW-1:0]    a_x;
    logic signed [DW-1:0]    a_y;
    logic signed [DW-1:0]    a_z;
    logic signed [DW-1:0]    b_x;
    logic signed [DW-1:0]    b_y;
    logic signed [DW-1:0]    b_z;
    logic signed [DW-1:0]    factor;
  } in_req_t;

  typedef struct packed {
    logic signed [DW-1:0]    res_x;
    logic signed [DW-1:0]    res_y;
    logic signed [DW-1:0]    res_z;
    logic signed [DW-1:0]    res_scalar;
    logic                    equal;
    logic [1:0]              fault;
  } out_res_t;

  typedef struct packed {
    logic                    sat;
    logic signed [DW-1:0]    val;
  } sat_t;

  // request sideband that travels alongside the root and divide pipelines
  typedef struct packed {
    logic [3:0]                          op;
    logic [NUM_LANES-1:0][DW-1:0]        b;
    logic [DW-1:0]                       fmag;
    logic                                fneg;
    logic                                eq;
    logic                                zf;
    logic                                rz;
    sat_t                                scal;
    sat_t [NUM_LANES-1:0]                vec;
    logic [NUM_LANES-1:0][DIVD_W-1:0]    dvd;
    logic [NUM_LANES-1:0]                aneg;
    logic [NUM_LANES-1:0]                qneg;
  } side_t;

  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    r.sat = (v > SMAX_W) || (v < SMIN_W);
    if (v > SMAX_W) begin
      r.val = SMAX_W[DW-1:0];
    end else if (v < SMIN_W) begin
      r.val = SMIN_W[DW-1:0];
    end else begin
      r.val = v[DW-1:0];
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] abs_mag(input logic signed [DW-1:0] v);
    logic signed [DW:0] e;
    e = (DW+1)'(v);
    if (e[DW]) begin
      e = -e;
    end
    return e[DW-1:0];
  endfunction

endpackage

// File: hw/rtl/vec3_vector_alu.sv
// ----------------------------------------------------------------------------
// vec3_vector_alu
// Three-component Q15.16 vector ALU: add, sub, scale, divide, compare,
// length, squared length, normalize, dot, cross and projection.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on in_req at a rising edge where start is high and
//   busy is low. busy stays low: the datapath is fully pipelined and takes
//   one request every cycle, with no gaps needed between requests.
//   Each request gives one result on out_res, valid for the single cycle in
//   which out_strobe is high. Results come out in request order.
//   The latency is set by the 32-stage square root pipeline followed by the
//   48-stage divider pipeline; every operation takes the same path so the
//   timing does not depend on the operation code.
//   Three lanes handle x, y and z side by side; the scalar sums are built
//   across the lanes, and a merge stage picks the result for the operation,
//   saturates and sets the fault code.
//   Synchronous active-low reset clears the in-flight valid bits, so no
//   strobe is produced for requests taken before reset.
//   The receiver cannot stall: out_res must be captured on the strobe.
// ----------------------------------------------------------------------------
module vec3_vector_alu (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  vva_pkg::in_req_t     in_req,
  output logic                 out_strobe,
  output vva_pkg::out_res_t    out_res
);

  localparam int NL = vva_pkg::NUM_LANES;
  localparam int DW = vva_pkg::DW;
  localparam int WW = vva_pkg::WIDE_W;
  localparam int VL = vva_pkg::LATENCY - 1;

  logic                  accept;
  logic [VL-1:0]         vld_r;
  vva_pkg::in_req_t      in_r, req2_r, req3_r;
  logic signed [DW-1:0]  a_v [NL];
  logic signed [DW-1:0]  b_v [NL];

  logic signed [2*DW-1:0]         prod    [NL];
  vva_pkg::sat_t                  lane_vec[NL];
  logic [vva_pkg::DIVD_W-1:0]     lane_dvd[NL];
  logic                           lane_neg[NL];

  logic [vva_pkg::SQ_W-1:0]       sq_sum, sq3_r;
  logic signed [WW-1:0]           dot_sum;
  vva_pkg::sat_t                  scal_nxt, scal3_r;
  logic                           eq3_r, eq_nxt, zf3_r, zf_nxt;
  vva_pkg::side_t                 side_s3, side_sel;
  vva_pkg::side_t                 sda_r [vva_pkg::ROOT_STAGES];
  vva_pkg::side_t                 sdb_r [vva_pkg::DIV_STAGES];
  logic [vva_pkg::ROOT_W-1:0]     root;
  logic [DW-1:0]                  dvs;
  logic [vva_pkg::DIVD_W-1:0]     quo [NL];

  vva_pkg::side_t                 sdq_r, sd1_r, sd2_r, sd3_r;
  logic signed [vva_pkg::DIVD_W:0] qs_r [NL];
  logic signed [vva_pkg::N_W-1:0]  n_nxt [NL];
  logic signed [vva_pkg::N_W-1:0]  n1_r [NL];
  logic signed [vva_pkg::N_W-1:0]  n2_r [NL];
  logic signed [vva_pkg::PQ_W-1:0] pq1_r [NL];
  logic signed [vva_pkg::PQ_W+1:0] pq_sum;
  logic signed [vva_pkg::PD_W-1:0] d2_r;
  vva_pkg::sat_t [NL-1:0]          divres1_r, divres2_r, divres3_r;
  logic [NL-1:0][vva_pkg::PR_W-1:0] pr3_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // input register and valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[VL-2:0], accept};
    end
    if (accept) begin
      in_r <= in_req;
    end
  end

  assign a_v[0] = in_r.a_x;
  assign a_v[1] = in_r.a_y;
  assign a_v[2] = in_r.a_z;
  assign b_v[0] = in_r.b_x;
  assign b_v[1] = in_r.b_y;
  assign b_v[2] = in_r.b_z;

  for (genvar i = 0; i < NL; i++) begin : g_lane
    vva_lane u_lane (
      .clk    (clk),
      .op     (in_r.operation),
      .a_self (a_v[i]),
      .a_nx   (a_v[(i+1)%NL]),
      .a_nn   (a_v[(i+2)%NL]),
      .b_self (b_v[i]),
      .b_nx   (b_v[(i+1)%NL]),
      .b_nn   (b_v[(i+2)%NL]),
      .factor (in_r.factor),
      .prod   (prod[i]),
      .vec    (lane_vec[i]),
      .dvd    (lane_dvd[i]),
      .a_neg  (lane_neg[i])
    );
  end

  // scalar sums across lanes
  always_comb begin
    sq_sum  = '0;
    dot_sum = '0;
    for (int i = 0; i < NL; i++) begin
      sq_sum  = sq_sum + $unsigned(prod[i]);
      dot_sum = dot_sum + WW'(prod[i]);
    end
    case (req2_r.operation)
      vva_pkg::OP_DOT:      scal_nxt = vva_pkg::sat32(dot_sum >>> vva_pkg::FRAC_BITS);
      vva_pkg::OP_SQLENGTH: scal_nxt = vva_pkg::sat32(WW'(sq_sum >> vva_pkg::FRAC_BITS));
      default:              scal_nxt = '0;
    endcase
    eq_nxt = (req2_r.a_x == req2_r.b_x) && (req2_r.a_y == req2_r.b_y)
             && (req2_r.a_z == req2_r.b_z);
    zf_nxt = (req2_r.factor == '0)
             || ((req2_r.a_x == '0) && (req2_r.a_y == '0) && (req2_r.a_z == '0));
  end

  always_ff @(posedge clk) begin
    req2_r  <= in_r;
    req3_r  <= req2_r;
    sq3_r   <= sq_sum;
    scal3_r <= scal_nxt;
    eq3_r   <= eq_nxt;
    zf3_r   <= zf_nxt;
  end

  always_comb begin
    side_s3      = '0;
    side_s3.op   = req3_r.operation;
    side_s3.b[0] = req3_r.b_x;
    side_s3.b[1] = req3_r.b_y;
    side_s3.b[2] = req3_r.b_z;
    side_s3.fmag = vva_pkg::abs_mag(req3_r.factor);
    side_s3.fneg = req3_r.factor[DW-1];
    side_s3.eq   = eq3_r;
    side_s3.zf   = zf3_r;
    side_s3.scal = scal3_r;
    for (int i = 0; i < NL; i++) begin
      side_s3.vec[i]  = lane_vec[i];
      side_s3.dvd[i]  = lane_dvd[i];
      side_s3.aneg[i] = lane_neg[i];
    end
  end

  vva_isqrt u_isqrt (
    .clk  (clk),
    .rad  (sq3_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    sda_r[0] <= side_s3;
    for (int k = 1; k < vva_pkg::ROOT_STAGES; k++) begin
      sda_r[k] <= sda_r[k-1];
    end
  end

  // divisor select: |factor| for divide, vector length otherwise
  always_comb begin
    side_sel    = sda_r[vva_pkg::ROOT_STAGES-1];
    side_sel.rz = (root == '0);
    if (side_sel.op == vva_pkg::OP_LENGTH) begin
      side_sel.scal = vva_pkg::sat32(WW'(root));
    end
    for (int i = 0; i < NL; i++) begin
      side_sel.qneg[i] = side_sel.aneg[i]
                         ^ ((side_sel.op == vva_pkg::OP_DIVIDE) & side_sel.fneg);
    end
    dvs = (side_sel.op == vva_pkg::OP_DIVIDE) ? side_sel.fmag : root;
  end

  for (genvar i = 0; i < NL; i++) begin : g_div
    vva_div u_div (
      .clk (clk),
      .dvd (side_sel.dvd[i]),
      .dvs (dvs),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    sdb_r[0] <= side_sel;
    for (int k = 1; k < vva_pkg::DIV_STAGES; k++) begin
      sdb_r[k] <= sdb_r[k-1];
    end
  end

  // signed quotient, then projection: d = b . n, r = n * d
  always_comb begin
    pq_sum = '0;
    for (int i = 0; i < NL; i++) begin
      n_nxt[i] = qs_r[i][vva_pkg::N_W-1:0];
      pq_sum   = pq_sum + (vva_pkg::PQ_W+2)'(pq1_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    sdq_r <= sdb_r[vva_pkg::DIV_STAGES-1];
    sd1_r <= sdq_r;
    sd2_r <= sd1_r;
    sd3_r <= sd2_r;
    for (int i = 0; i < NL; i++) begin
      qs_r[i] <= sdb_r[vva_pkg::DIV_STAGES-1].qneg[i] ? -$signed({1'b0, quo[i]})
                                                      :  $signed({1'b0, quo[i]});
      divres1_r[i] <= vva_pkg::sat32(WW'(qs_r[i]));
      n1_r[i]      <= n_nxt[i];
      pq1_r[i]     <= vva_pkg::PQ_W'($signed(sdq_r.b[i])) * vva_pkg::PQ_W'(n_nxt[i]);
      n2_r[i]      <= n1_r[i];
      divres2_r[i] <= divres1_r[i];
      divres3_r[i] <= divres2_r[i];
      pr3_r[i]     <= vva_pkg::PR_W'(n2_r[i]) * vva_pkg::PR_W'(d2_r);
    end
    d2_r <= vva_pkg::PD_W'(pq_sum >>> vva_pkg::FRAC_BITS);
  end

  vva_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld    (vld_r[VL-1]),
    .side   (sd3_r),
    .divres (divres3_r),
    .prj    (pr3_r),
    .strobe (out_strobe),
    .res    (out_res)
  );

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(vva_pkg::LATENCY) out_strobe)
    else $error("accepted request gave no result at the fixed latency");

  a_zero_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.fault == vva_pkg::FAULT_ZERO) |->
      (out_res.res_x == '0) && (out_res.res_y == '0) && (out_res.res_z == '0)
      && (out_res.res_scalar == '0) && !out_res.equal)
    else $error("zero-divisor fault with nonzero result");

  a_equal_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.equal) |->
      (out_res.fault == vva_pkg::FAULT_NONE) && (out_res.res_scalar == '0)
      && (out_res.res_x == '0) && (out_res.res_y == '0) && (out_res.res_z == '0))
    else $error("compare result mixed with other outputs");
`endif

endmodule

// File: hw/rtl/vva_isqrt.sv
// ----------------------------------------------------------------------------
// vva_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vva_isqrt (
  input  logic                          clk,
  input  logic [vva_pkg::SQ_W-1:0]      rad,
  output logic [vva_pkg::ROOT_W-1:0]    root
);

  localparam int NS = vva_pkg::ROOT_STAGES;
  localparam int W  = vva_pkg::SQ_W;

  logic [W-1:0] rem_r   [NS];
  logic [W-1:0] res_r   [NS];
  logic [W-1:0] rem_nxt [NS];
  logic [W-1:0] res_nxt [NS];
  logic [W-1:0] rem_in  [NS];
  logic [W-1:0] res_in  [NS];
  logic [W-1:0] trial   [NS];
  logic [W-1:0] bitv    [NS];

  always_comb begin
    rem_in[0] = rad;
    res_in[0] = '0;
    for (int k = 1; k < NS; k++) begin
      rem_in[k] = rem_r[k-1];
      res_in[k] = res_r[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      bitv[k]  = W'(1) << (W - 2 - 2 * k);
      trial[k] = res_in[k] + bitv[k];
      if (rem_in[k] >= trial[k]) begin
        rem_nxt[k] = rem_in[k] - trial[k];
        res_nxt[k] = (res_in[k] >> 1) + bitv[k];
      end else begin
        rem_nxt[k] = rem_in[k];
        res_nxt[k] = res_in[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      rem_r[k] <= rem_nxt[k];
      res_r[k] <= res_nxt[k];
    end
  end

  assign root = res_r[NS-1][vva_pkg::ROOT_W-1:0];

endmodule

// File: hw/rtl/vva_div.sv
// ----------------------------------------------------------------------------
// vva_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vva_div (
  input  logic                          clk,
  input  logic [vva_pkg::DIVD_W-1:0]    dvd,
  input  logic [vva_pkg::DW-1:0]        dvs,
  output logic [vva_pkg::DIVD_W-1:0]    quo
);

  localparam int NS = vva_pkg::DIV_STAGES;
  localparam int QW = vva_pkg::DIVD_W;
  localparam int RW = vva_pkg::DW;

  logic [RW-1:0] rem_r   [NS];
  logic [QW-1:0] dq_r    [NS];
  logic [RW-1:0] dvs_r   [NS];
  logic [RW-1:0] rem_nxt [NS];
  logic [QW-1:0] dq_nxt  [NS];
  logic [RW-1:0] rem_in  [NS];
  logic [QW-1:0] dq_in   [NS];
  logic [RW-1:0] dvs_in  [NS];
  logic [RW:0]   trial   [NS];
  logic [RW:0]   diff    [NS];
  logic          ge      [NS];

  always_comb begin
    rem_in[0] = '0;
    dq_in[0]  = dvd;
    dvs_in[0] = dvs;
    for (int k = 1; k < NS; k++) begin
      rem_in[k] = rem_r[k-1];
      dq_in[k]  = dq_r[k-1];
      dvs_in[k] = dvs_r[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      trial[k]   = {rem_in[k], dq_in[k][QW-1]};
      ge[k]      = trial[k] >= {1'b0, dvs_in[k]};
      diff[k]    = trial[k] - {1'b0, dvs_in[k]};
      rem_nxt[k] = ge[k] ? diff[k][RW-1:0] : trial[k][RW-1:0];
      dq_nxt[k]  = {dq_in[k][QW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      rem_r[k] <= rem_nxt[k];
      dq_r[k]  <= dq_nxt[k];
      dvs_r[k] <= dvs_in[k];
    end
  end

  assign quo = dq_r[NS-1];

endmodule

// File: hw/rtl/vva_lane.sv
// ----------------------------------------------------------------------------
// vva_lane
// One component lane: products, elementwise results and divide operand.
// ----------------------------------------------------------------------------
module vva_lane (
  input  logic                                clk,
  input  logic [3:0]                          op,
  input  logic signed [vva_pkg::DW-1:0]       a_self,
  input  logic signed [vva_pkg::DW-1:0]       a_nx,
  input  logic signed [vva_pkg::DW-1:0]       a_nn,
  input  logic signed [vva_pkg::DW-1:0]       b_self,
  input  logic signed [vva_pkg::DW-1:0]       b_nx,
  input  logic signed [vva_pkg::DW-1:0]       b_nn,
  input  logic signed [vva_pkg::DW-1:0]       factor,
  output logic signed [2*vva_pkg::DW-1:0]     prod,
  output vva_pkg::sat_t                       vec,
  output logic [vva_pkg::DIVD_W-1:0]          dvd,
  output logic                                a_neg
);

  localparam int DW = vva_pkg::DW;
  localparam int PW = 2 * vva_pkg::DW;
  localparam int WW = vva_pkg::WIDE_W;

  logic signed [DW-1:0] opa, opb;
  logic signed [PW-1:0] prod_r, prod_nxt, crs_r, crs_nxt;
  logic [3:0]           op_r;
  logic signed [DW-1:0] a_r, b_r;
  vva_pkg::sat_t        vec_r, vec_nxt;
  logic [vva_pkg::DIVD_W-1:0] dvd_r, dvd_nxt;
  logic                 neg_r;

  always_comb begin
    opa = (op == vva_pkg::OP_CROSS) ? a_nx : a_self;
    case (op)
      vva_pkg::OP_CROSS: opb = b_nn;
      vva_pkg::OP_SCALE: opb = factor;
      vva_pkg::OP_DOT:   opb = b_self;
      default:           opb = a_self;
    endcase
    prod_nxt = PW'(opa) * PW'(opb);
    crs_nxt  = PW'(a_nn) * PW'(b_nx);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    crs_r  <= crs_nxt;
    op_r   <= op;
    a_r    <= a_self;
    b_r    <= b_self;
  end

  always_comb begin
    case (op_r)
      vva_pkg::OP_ADD:   vec_nxt = vva_pkg::sat32(WW'(a_r) + WW'(b_r));
      vva_pkg::OP_SUB:   vec_nxt = vva_pkg::sat32(WW'(a_r) - WW'(b_r));
      vva_pkg::OP_SCALE: vec_nxt = vva_pkg::sat32(WW'(prod_r) >>> vva_pkg::FRAC_BITS);
      vva_pkg::OP_CROSS: vec_nxt = vva_pkg::sat32((WW'(prod_r) - WW'(crs_r))
                                                  >>> vva_pkg::FRAC_BITS);
      default:           vec_nxt = '0;
    endcase
    dvd_nxt = {vva_pkg::abs_mag(a_r), {vva_pkg::FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
    dvd_r <= dvd_nxt;
    neg_r <= a_r[DW-1];
  end

  assign prod  = prod_r;
  assign vec   = vec_r;
  assign dvd   = dvd_r;
  assign a_neg = neg_r;

endmodule

// File: hw/rtl/vva_merge.sv
// ----------------------------------------------------------------------------
// vva_merge
// Merges lane results per operation, saturation and fault, output register.
// ----------------------------------------------------------------------------
module vva_merge (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                vld,
  input  vva_pkg::side_t                                      side,
  input  vva_pkg::sat_t [vva_pkg::NUM_LANES-1:0]              divres,
  input  logic [vva_pkg::NUM_LANES-1:0][vva_pkg::PR_W-1:0]    prj,
  output logic                                                strobe,
  output vva_pkg::out_res_t                                   res
);

  localparam int NL = vva_pkg::NUM_LANES;

  vva_pkg::sat_t [NL-1:0] prj_sat;
  vva_pkg::sat_t [NL-1:0] vec_sel;
  vva_pkg::sat_t          scal_sel;
  logic                   eq_sel;
  logic [1:0]             flt_sel;
  logic                   any_sat;
  vva_pkg::out_res_t      res_r, res_nxt;
  logic                   strobe_r;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      prj_sat[i] = vva_pkg::sat32(vva_pkg::WIDE_W'($signed(prj[i]) >>> vva_pkg::FRAC_BITS));
    end
    vec_sel  = '0;
    scal_sel = '0;
    eq_sel   = 1'b0;
    flt_sel  = vva_pkg::FAULT_NONE;
    case (side.op)
      vva_pkg::OP_ADD, vva_pkg::OP_SUB, vva_pkg::OP_SCALE, vva_pkg::OP_CROSS: begin
        vec_sel = side.vec;
      end
      vva_pkg::OP_DIVIDE: begin
        if (side.zf) begin
          flt_sel = vva_pkg::FAULT_ZERO;
        end else begin
          vec_sel = divres;
        end
      end
      vva_pkg::OP_COMPARE: begin
        eq_sel = side.eq;
      end
      vva_pkg::OP_LENGTH, vva_pkg::OP_SQLENGTH, vva_pkg::OP_DOT: begin
        scal_sel = side.scal;
      end
      vva_pkg::OP_NORMALIZE: begin
        if (!side.rz) begin
          vec_sel = divres;
        end
      end
      vva_pkg::OP_PROJECT: begin
        if (!side.rz) begin
          vec_sel = prj_sat;
        end
      end
      default: begin
        vec_sel = '0;
      end
    endcase
    any_sat = scal_sel.sat;
    for (int i = 0; i < NL; i++) begin
      any_sat = any_sat | vec_sel[i].sat;
    end
    if (flt_sel == vva_pkg::FAULT_NONE && any_sat) begin
      flt_sel = vva_pkg::FAULT_SAT;
    end
    res_nxt.res_x      = vec_sel[0].val;
    res_nxt.res_y      = vec_sel[1].val;
    res_nxt.res_z      = vec_sel[2].val;
    res_nxt.res_scalar = scal_sel.val;
    res_nxt.equal      = eq_sel;
    res_nxt.fault      = flt_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld;
    end
    if (vld) begin
      res_r <= res_nxt;
    end
  end

  assign strobe = strobe_r;
  assign res    = res_r;

endmodule

// File: tb/vec3_vector_alu_tb.sv
// ----------------------------------------------------------------------------
// vec3_vector_alu_tb
// Self-checking bench for the vector ALU. Directed corner requests, then
// random requests with random start gaps. Results from the strobe are checked
// in order against a wide-integer model of each operation.
// ----------------------------------------------------------------------------
module vec3_vector_alu_tb;

  typedef logic signed [127:0] wide_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_REQS   = 1300;

  class vec_scoreboard;
    vva_pkg::out_res_t pending_q[$];
    int                errors;

    function new();
      errors = 0;
    endfunction

    static function logic [63:0] root64(logic [63:0] v);
      logic [63:0] res, bt;
      res = '0;
      bt  = 64'h1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return res;
    endfunction

    static function logic [63:0] sum_sq(wide_t v[3]);
      wide_t t;
      t = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      return t[63:0];
    endfunction

    static function bit unit_vec(wide_t a[3], output wide_t n[3]);
      wide_t len;
      len = wide_t'({64'd0, root64(sum_sq(a))});
      for (int i = 0; i < 3; i++) n[i] = 0;
      if (len == 0) return 1'b0;
      for (int i = 0; i < 3; i++) n[i] = (a[i] <<< vva_pkg::FRAC_BITS) / len;
      return 1'b1;
    endfunction

    static function wide_t dot_floor(wide_t p[3], wide_t q[3]);
      return (p[0] * q[0] + p[1] * q[1] + p[2] * q[2]) >>> vva_pkg::FRAC_BITS;
    endfunction

    static function logic signed [31:0] clamp32(wide_t v, inout bit sat);
      if (v > wide_t'(32'sh7fffffff)) begin
        sat = 1'b1;
        return 32'sh7fffffff;
      end
      if (v < wide_t'(-32'sh7fffffff - 1)) begin
        sat = 1'b1;
        return 32'sh80000000;
      end
      return v[31:0];
    endfunction

    static function vva_pkg::out_res_t predict_vec_result(vva_pkg::in_req_t r);
      wide_t             a[3], b[3], v[3], n[3], f, s, d;
      bit                sat, eq, zf;
      vva_pkg::out_res_t o;
      a[0] = wide_t'(r.a_x); a[1] = wide_t'(r.a_y); a[2] = wide_t'(r.a_z);
      b[0] = wide_t'(r.b_x); b[1] = wide_t'(r.b_y); b[2] = wide_t'(r.b_z);
      f = wide_t'(r.factor);
      for (int i = 0; i < 3; i++) v[i] = 0;
      s = 0; sat = 0; eq = 0; zf = 0;
      case (r.operation)
        vva_pkg::OP_ADD: for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
        vva_pkg::OP_SUB: for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
        vva_pkg::OP_SCALE: begin
          for (int i = 0; i < 3; i++) v[i] = (a[i] * f) >>> vva_pkg::FRAC_BITS;
        end
        vva_pkg::OP_DIVIDE: begin
          if (f == 0 || (a[0] == 0 && a[1] == 0 && a[2] == 0)) begin
            zf = 1;
          end else begin
            for (int i = 0; i < 3; i++) v[i] = (a[i] <<< vva_pkg::FRAC_BITS) / f;
          end
        end
        vva_pkg::OP_COMPARE: eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
        vva_pkg::OP_LENGTH:  s = wide_t'({64'd0, root64(sum_sq(a))});
        vva_pkg::OP_SQLENGTH: s = wide_t'({64'd0, sum_sq(a) >> vva_pkg::FRAC_BITS});
        vva_pkg::OP_NORMALIZE: void'(unit_vec(a, v));
        vva_pkg::OP_DOT:     s = dot_floor(a, b);
        vva_pkg::OP_CROSS: begin
          v[0] = (a[1] * b[2] - a[2] * b[1]) >>> vva_pkg::FRAC_BITS;
          v[1] = (a[2] * b[0] - a[0] * b[2]) >>> vva_pkg::FRAC_BITS;
          v[2] = (a[0] * b[1] - a[1] * b[0]) >>> vva_pkg::FRAC_BITS;
        end
        vva_pkg::OP_PROJECT: begin
          if (unit_vec(a, n)) begin
            d = dot_floor(b, n);
            for (int i = 0; i < 3; i++) v[i] = (n[i] * d) >>> vva_pkg::FRAC_BITS;
          end
        end
        default: ;
      endcase
      o.res_x      = clamp32(v[0], sat);
      o.res_y      = clamp32(v[1], sat);
      o.res_z      = clamp32(v[2], sat);
      o.res_scalar = clamp32(s, sat);
      o.equal      = eq;
      o.fault      = zf ? vva_pkg::FAULT_ZERO
                        : (sat ? vva_pkg::FAULT_SAT : vva_pkg::FAULT_NONE);
      return o;
    endfunction

    function void note_request(vva_pkg::in_req_t r);
      pending_q.push_back(predict_vec_result(r));
    endfunction

    function void check_result(vva_pkg::out_res_t got);
      vva_pkg::out_res_t exp;
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.res_x !== exp.res_x) begin
        $error("res_x exp %0d got %0d", exp.res_x, got.res_x); errors++;
      end
      if (got.res_y !== exp.res_y) begin
        $error("res_y exp %0d got %0d", exp.res_y, got.res_y); errors++;
      end
      if (got.res_z !== exp.res_z) begin
        $error("res_z exp %0d got %0d", exp.res_z, got.res_z); errors++;
      end
      if (got.res_scalar !== exp.res_scalar) begin
        $error("res_scalar exp %0d got %0d", exp.res_scalar, got.res_scalar); errors++;
      end
      if (got.equal !== exp.equal) begin
        $error("equal exp %0d got %0d", exp.equal, got.equal); errors++;
      end
      if (got.fault !== exp.fault) begin
        $error("fault exp %0d got %0d", exp.fault, got.fault); errors++;
      end
    endfunction
  endclass

  logic              clk    = 1'b0;
  logic              rst_n  = 1'b0;
  logic              start  = 1'b0;
  vva_pkg::in_req_t  in_req = '0;
  logic              busy;
  logic              out_strobe;
  vva_pkg::out_res_t out_res;
  int                cycles = 0;

  vec_scoreboard sb = new();

  vec3_vector_alu u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("vec3_vector_alu: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_res);
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3, 4:    return 32'($urandom_range(0, 32'h000fffff)) - 32'h00080000;
      5, 6:    return 32'($urandom_range(0, 32'h03ffffff)) - 32'h02000000;
      7: begin
        case ($urandom_range(0, 4))
          0: return 32'h0;
          1: return 32'h1;
          2: return 32'hffffffff;
          3: return 32'h80000000;
          default: return 32'h7fffffff;
        endcase
      end
      default: return 32'($urandom_range(0, 32'h0007ffff)) - 32'h00040000;
    endcase
  endfunction

  task automatic send_request(vva_pkg::in_req_t r, bit allow_gap);
    int gap, sel;
    in_req <= r;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    gap = 0;
    if (allow_gap) begin
      sel = $urandom_range(0, 99);
      if (sel >= 98)      gap = $urandom_range(30, 120);
      else if (sel >= 90) gap = $urandom_range(4, 12);
      else if (sel >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (sb.pending_q.size() > 0) @(posedge clk);
  endtask

  function automatic vva_pkg::in_req_t mk(logic [3:0] op, logic [31:0] ax,
                                          logic [31:0] ay, logic [31:0] az,
                                          logic [31:0] bx, logic [31:0] by,
                                          logic [31:0] bz, logic [31:0] f);
    vva_pkg::in_req_t r;
    r.operation = op;
    r.a_x = ax; r.a_y = ay; r.a_z = az;
    r.b_x = bx; r.b_y = by; r.b_z = bz;
    r.factor = f;
    return r;
  endfunction

  initial begin
    vva_pkg::in_req_t r;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners
    send_request(mk(vva_pkg::OP_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'h7fffffff,
                    32'h80000000, 32'hffffffff, 0), 0);
    send_request(mk(vva_pkg::OP_SUB, 32'h80000000, 32'h7fffffff, 32'h0, 32'h7fffffff,
                    32'h80000000, 32'h0, 0), 0);
    send_request(mk(vva_pkg::OP_SCALE, 32'h7fffffff, 32'h80000000, 32'h00010000,
                    0, 0, 0, 32'h80000000), 0);
    send_request(mk(vva_pkg::OP_SCALE, 32'hffffffff, 32'h3, 32'h00020000, 0, 0, 0,
                    32'h00008000), 0);
    send_request(mk(vva_pkg::OP_DIVIDE, 32'h00010000, 32'h1, 32'hffffffff, 0, 0, 0,
                    32'h0), 0);
    send_request(mk(vva_pkg::OP_DIVIDE, 0, 0, 0, 0, 0, 0, 32'h00010000), 0);
    send_request(mk(vva_pkg::OP_DIVIDE, 32'h7fffffff, 32'h80000000, 32'h5, 0, 0, 0,
                    32'h1), 0);
    send_request(mk(vva_pkg::OP_DIVIDE, 32'h00030000, 32'hfffd0000, 32'h7, 0, 0, 0,
                    32'hfffe0000), 0);
    send_request(mk(vva_pkg::OP_COMPARE, 1, 2, 3, 1, 2, 3, 0), 0);
    send_request(mk(vva_pkg::OP_COMPARE, 1, 2, 3, 1, 2, 4, 0), 0);
    send_request(mk(vva_pkg::OP_LENGTH, 32'h80000000, 32'h80000000, 32'h80000000,
                    0, 0, 0, 0), 0);
    send_request(mk(vva_pkg::OP_LENGTH, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0), 0);
    send_request(mk(vva_pkg::OP_SQLENGTH, 32'h80000000, 32'h7fffffff, 32'h80000000,
                    0, 0, 0, 0), 0);
    send_request(mk(vva_pkg::OP_SQLENGTH, 32'h00010000, 32'hffff0000, 32'h1,
                    0, 0, 0, 0), 0);
    send_request(mk(vva_pkg::OP_NORMALIZE, 0, 0, 0, 0, 0, 0, 0), 0);
    send_request(mk(vva_pkg::OP_NORMALIZE, 32'h1, 0, 0, 0, 0, 0, 0), 0);
    send_request(mk(vva_pkg::OP_NORMALIZE, 32'h80000000, 32'h7fffffff, 32'h5,
                    0, 0, 0, 0), 0);
    send_request(mk(vva_pkg::OP_DOT, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'h80000000, 0), 0);
    send_request(mk(vva_pkg::OP_DOT, 32'hffffffff, 2, 3, 1, 32'hfffffffe, 5, 0), 0);
    send_request(mk(vva_pkg::OP_CROSS, 32'h80000000, 32'h7fffffff, 32'h80000000,
                    32'h7fffffff, 32'h80000000, 32'h80000000, 0), 0);
    send_request(mk(vva_pkg::OP_PROJECT, 0, 0, 0, 32'h00010000, 2, 3, 0), 0);
    send_request(mk(vva_pkg::OP_PROJECT, 32'h80000000, 32'h1, 0, 32'h7fffffff,
                    32'h80000000, 32'h7fffffff, 0), 0);
    send_request(mk(4'd11, 1, 2, 3, 4, 5, 6, 7), 0);
    send_request(mk(4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                    32'hffffffff, 32'hffffffff, 32'hffffffff), 0);
    start <= 1'b0;
    drain();

    for (int k = 0; k < RAND_REQS; k++) begin
      r.operation = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                                 : 4'($urandom_range(0, 10));
      r.a_x = pick_word(); r.a_y = pick_word(); r.a_z = pick_word();
      r.b_x = pick_word(); r.b_y = pick_word(); r.b_z = pick_word();
      r.factor = pick_word();
      if (r.operation == vva_pkg::OP_COMPARE && $urandom_range(0, 1)) begin
        r.b_x = r.a_x; r.b_y = r.a_y; r.b_z = r.a_z;
        if ($urandom_range(0, 1)) r.b_z[$urandom_range(0, 31)] ^= 1'b1;
      end
      if (r.operation == vva_pkg::OP_DIVIDE && $urandom_range(0, 9) == 0) r.factor = '0;
      if ($urandom_range(0, 29) == 0) begin
        r.a_x = '0; r.a_y = '0; r.a_z = '0;
      end
      send_request(r, 1);
      if (k == RAND_REQS / 2) begin
        start <= 1'b0;
        drain();
      end
    end
    start <= 1'b0;
    drain();
    repeat (vva_pkg::LATENCY + 10) @(posedge clk);

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("vec3_vector_alu: match");
    end else begin
      $display("vec3_vector_alu: mismatch");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/vva_pkg.sv
hw/rtl/vva_isqrt.sv
hw/rtl/vva_div.sv
hw/rtl/vva_lane.sv
hw/rtl/vva_merge.sv
hw/rtl/vec3_vector_alu.sv
tb/vec3_vector_alu_tb.sv
